// ===== hdl/swza_pkg.sv =====
// Shared constants, types and helpers of the sliding-window z-score anomaly detector.
`timescale 1ns / 1ps

package swza_pkg;

   localparam int unsigned WINDOW_DEPTH_DEFAULT = 64;
   localparam int unsigned SAMPLE_BITS_DEFAULT  = 24;

   localparam int unsigned COUNT_CFG_BITS = 6;
   localparam int unsigned Z_BITS         = 8;
   localparam int unsigned DEV_BITS       = 16;
   localparam int unsigned Z_FRAC_BITS    = 4;
   localparam int unsigned MUL_DIGIT_BITS = 4;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 16;

   localparam logic [COUNT_CFG_BITS-1:0] MIN_SAMPLES_RESET   = 6'd10;
   localparam logic [COUNT_CFG_BITS-1:0] WINDOW_LEN_RESET    = 6'd50;
   localparam logic [Z_BITS-1:0]         Z_THRESHOLD_RESET   = 8'd48;
   localparam logic [DEV_BITS-1:0]       MIN_DEVIATION_RESET = 16'd512;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_SAMPLES,
      CSR_WINDOW_LEN,
      CSR_Z_THRESHOLD,
      CSR_MIN_DEVIATION
   } swza_csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DROP_RD,
      ST_DROP_SQ,
      ST_APPEND,
      ST_NQ,
      ST_SS,
      ST_NX,
      ST_LL,
      ST_ZZ,
      ST_ZD,
      ST_MD,
      ST_N2,
      ST_FL,
      ST_DIV,
      ST_RESULT
   } swza_state_type;

   typedef struct packed {
      logic start;
      logic div;
   } swza_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } swza_sts_type;

   function automatic int unsigned swza_max(input int unsigned a, input int unsigned b);
      return (a > b) ? a : b;
   endfunction

endpackage

// ===== hdl/swza_if.sv =====
// Valid/ready channels for sample items and result items.
`timescale 1ns / 1ps

interface swza_req_if #(
   parameter int unsigned SAMPLE_BITS = swza_pkg::SAMPLE_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] rtt_sample;

   modport source (output valid, output rtt_sample, input ready);
   modport sink   (input valid, input rtt_sample, output ready);
endinterface

interface swza_rsp_if #(
   parameter int unsigned SAMPLE_BITS = swza_pkg::SAMPLE_BITS_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic                   evaluated;
   logic                   anomaly;
   logic [SAMPLE_BITS-1:0] window_mean;

   modport source (output valid, output evaluated, output anomaly, output window_mean,
                   input ready);
   modport sink   (input valid, input evaluated, input anomaly, input window_mean,
                   output ready);
endinterface

// ===== hdl/sliding_window_zscore_anomaly_top.sv =====
// Sliding-window z-score anomaly detector for round-trip-time samples: top level.
// A zero sample goes straight to the result register. A sample that is appended but not
// evaluated passes only the append state, after the drop states when the window is full; an evaluated sample
// also runs the NQ to DIV states on the shared 4-bit-per-cycle multiplier and 1-bit-per-cycle mean divider.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous, clears the window and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps

module sliding_window_zscore_anomaly_top #(
   parameter int unsigned WINDOW_DEPTH = swza_pkg::WINDOW_DEPTH_DEFAULT,
   parameter int unsigned SAMPLE_BITS  = swza_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   swza_req_if.sink                            req_ch,
   swza_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [swza_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [swza_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   localparam int unsigned CFG_BITS  = swza_pkg::COUNT_CFG_BITS;
   localparam int unsigned Z_BITS    = swza_pkg::Z_BITS;
   localparam int unsigned DEV_BITS  = swza_pkg::DEV_BITS;
   localparam int unsigned PTR_BITS  = $clog2(WINDOW_DEPTH);
   localparam int unsigned CNT_BITS  = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SUM_BITS  = SAMPLE_BITS + PTR_BITS;
   localparam int unsigned SQ_BITS   = 2 * SAMPLE_BITS + PTR_BITS;
   localparam int unsigned D_BITS    = CNT_BITS + SQ_BITS;
   localparam int unsigned DIFF_BITS = CNT_BITS + SAMPLE_BITS;
   localparam int unsigned LHS_BITS  = DIFF_BITS + swza_pkg::Z_FRAC_BITS;
   localparam int unsigned BIG_BITS  = 2 * LHS_BITS;
   localparam int unsigned ZZ_BITS   = 2 * Z_BITS;
   localparam int unsigned MD2_BITS  = 2 * DEV_BITS;
   localparam int unsigned N2_BITS   = 2 * CNT_BITS;
   localparam int unsigned SQX_BITS  = 2 * SAMPLE_BITS;
   localparam int unsigned PROD_BITS = swza_pkg::swza_max(ZZ_BITS + D_BITS, BIG_BITS);
   localparam int unsigned OPB_BITS  =
      swza_pkg::swza_max(LHS_BITS, swza_pkg::swza_max(DEV_BITS, N2_BITS));
   localparam int unsigned CMP_BITS  = swza_pkg::swza_max(CNT_BITS, CFG_BITS);

   swza_pkg::swza_state_type state_ff, state_in;

   logic [CFG_BITS-1:0]    min_samples_ff, window_len_ff;
   logic [Z_BITS-1:0]      z_threshold_ff;
   logic [DEV_BITS-1:0]    min_deviation_ff;

   logic [PTR_BITS-1:0]    ptr_ff, ptr_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [SQ_BITS-1:0]     sq_ff, sq_in;

   logic [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [SAMPLE_BITS-1:0] drop_v_ff, drop_v_in;
   logic                   pre_drop_ff, pre_drop_in;
   logic                   eval_ff, eval_in;
   logic [D_BITS-1:0]      dd_ff, dd_in;
   logic                   pos_ff, pos_in;
   logic [LHS_BITS-1:0]    lhs_ff, lhs_in;
   logic [BIG_BITS-1:0]    big_ff, big_in;
   logic [ZZ_BITS-1:0]     zz_ff, zz_in;
   logic                   above_ff, above_in;
   logic [MD2_BITS-1:0]    md2_ff, md2_in;
   logic [N2_BITS-1:0]     n2_ff, n2_in;
   logic                   over_ff, over_in;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_eval_ff, rsp_eval_in;
   logic                   rsp_anom_ff, rsp_anom_in;
   logic [SAMPLE_BITS-1:0] rsp_mean_ff, rsp_mean_in;

   swza_pkg::swza_ctl_type unit_ctl;
   swza_pkg::swza_sts_type unit_sts;
   logic [PROD_BITS-1:0]   unit_a;
   logic [OPB_BITS-1:0]    unit_b;
   logic [PROD_BITS-1:0]   unit_result;

   logic                   ram_wr_en;
   logic [PTR_BITS-1:0]    ram_wr_addr;
   logic [SAMPLE_BITS-1:0] ram_rd_data;

   logic                   req_accept;
   logic                   rsp_load;
   logic                   count_full;
   logic                   eval_now;
   logic                   drop_post;
   logic [CNT_BITS:0]      tail_sum;
   logic [CNT_BITS:0]      tail_wrap;
   logic [PTR_BITS-1:0]    ptr_next;
   logic [SUM_BITS:0]      sum_add;
   logic [SQ_BITS:0]       sq_add;
   logic [SQ_BITS-1:0]     v_sq;
   logic [D_BITS-1:0]      ss;
   logic [DIFF_BITS-1:0]   nx;
   logic [DIFF_BITS-1:0]   sum_ext;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_samples_ff   <= swza_pkg::MIN_SAMPLES_RESET;
         window_len_ff    <= swza_pkg::WINDOW_LEN_RESET;
         z_threshold_ff   <= swza_pkg::Z_THRESHOLD_RESET;
         min_deviation_ff <= swza_pkg::MIN_DEVIATION_RESET;
      end else if (csr_write_enable) begin
         case (swza_pkg::swza_csr_type'(csr_index))
            swza_pkg::CSR_MIN_SAMPLES:   min_samples_ff   <= csr_write_data[CFG_BITS-1:0];
            swza_pkg::CSR_WINDOW_LEN:    window_len_ff    <= csr_write_data[CFG_BITS-1:0];
            swza_pkg::CSR_Z_THRESHOLD:   z_threshold_ff   <= csr_write_data[Z_BITS-1:0];
            swza_pkg::CSR_MIN_DEVIATION: min_deviation_ff <= csr_write_data[DEV_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign req_accept = req_ch.valid & req_ch.ready;
   assign rsp_load   = (state_ff == swza_pkg::ST_RESULT) & (~rsp_valid_ff | rsp_ch.ready);
   assign count_full = (count_ff >= CNT_BITS'(WINDOW_DEPTH));
   assign eval_now   = (CMP_BITS'(count_ff) + CMP_BITS'(1)) > CMP_BITS'(min_samples_ff);
   assign drop_post  = CMP_BITS'(count_ff) > CMP_BITS'(window_len_ff);

   assign tail_sum    = (CNT_BITS + 1)'(ptr_ff) + (CNT_BITS + 1)'(count_ff);
   assign tail_wrap   = (tail_sum >= (CNT_BITS + 1)'(WINDOW_DEPTH)) ?
                        tail_sum - (CNT_BITS + 1)'(WINDOW_DEPTH) : tail_sum;
   assign ram_wr_addr = tail_wrap[PTR_BITS-1:0];
   assign ptr_next    = (ptr_ff == PTR_BITS'(WINDOW_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   assign sum_add = {1'b0, sum_ff} + (SUM_BITS + 1)'(x_ff);
   assign sq_add  = {1'b0, sq_ff} + (SQ_BITS + 1)'(unit_result[SQX_BITS-1:0]);
   assign v_sq    = SQ_BITS'(unit_result[SQX_BITS-1:0]);
   assign ss      = unit_result[D_BITS-1:0];
   assign nx      = unit_result[DIFF_BITS-1:0];
   assign sum_ext = DIFF_BITS'(sum_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         swza_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_ch.rtt_sample == '0) begin
                  state_in = swza_pkg::ST_RESULT;
               end else if (count_full) begin
                  state_in = swza_pkg::ST_DROP_RD;
               end else begin
                  state_in = swza_pkg::ST_APPEND;
               end
            end
         end
         swza_pkg::ST_DROP_RD: state_in = swza_pkg::ST_DROP_SQ;
         swza_pkg::ST_DROP_SQ: begin
            if (unit_sts.done) begin
               state_in = pre_drop_ff ? swza_pkg::ST_APPEND : swza_pkg::ST_RESULT;
            end
         end
         swza_pkg::ST_APPEND: begin
            if (unit_sts.done) begin
               state_in = eval_now ? swza_pkg::ST_NQ : swza_pkg::ST_RESULT;
            end
         end
         swza_pkg::ST_NQ: if (unit_sts.done) state_in = swza_pkg::ST_SS;
         swza_pkg::ST_SS: if (unit_sts.done) state_in = swza_pkg::ST_NX;
         swza_pkg::ST_NX: if (unit_sts.done) state_in = swza_pkg::ST_LL;
         swza_pkg::ST_LL: begin
            if (!pos_ff) begin
               state_in = swza_pkg::ST_MD;
            end else if (unit_sts.done) begin
               state_in = swza_pkg::ST_ZZ;
            end
         end
         swza_pkg::ST_ZZ: if (unit_sts.done) state_in = swza_pkg::ST_ZD;
         swza_pkg::ST_ZD: if (unit_sts.done) state_in = swza_pkg::ST_MD;
         swza_pkg::ST_MD: if (unit_sts.done) state_in = swza_pkg::ST_N2;
         swza_pkg::ST_N2: if (unit_sts.done) state_in = swza_pkg::ST_FL;
         swza_pkg::ST_FL: if (unit_sts.done) state_in = swza_pkg::ST_DIV;
         swza_pkg::ST_DIV: begin
            if (unit_sts.done) begin
               state_in = drop_post ? swza_pkg::ST_DROP_RD : swza_pkg::ST_RESULT;
            end
         end
         swza_pkg::ST_RESULT: if (rsp_load) state_in = swza_pkg::ST_IDLE;
         default: state_in = swza_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_ch.ready   = (state_ff == swza_pkg::ST_IDLE);
      unit_ctl.start = 1'b0;
      unit_ctl.div   = 1'b0;
      unit_a         = '0;
      unit_b         = '0;
      ram_wr_en      = 1'b0;
      case (state_ff)
         swza_pkg::ST_DROP_SQ: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(ram_rd_data);
            unit_b         = OPB_BITS'(ram_rd_data);
         end
         swza_pkg::ST_APPEND: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(x_ff);
            unit_b         = OPB_BITS'(x_ff);
            ram_wr_en      = unit_sts.done;
         end
         swza_pkg::ST_NQ: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(sq_ff);
            unit_b         = OPB_BITS'(count_ff);
         end
         swza_pkg::ST_SS: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(sum_ff);
            unit_b         = OPB_BITS'(sum_ff);
         end
         swza_pkg::ST_NX: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(x_ff);
            unit_b         = OPB_BITS'(count_ff);
         end
         swza_pkg::ST_LL: begin
            unit_ctl.start = pos_ff & ~unit_sts.busy;
            unit_a         = PROD_BITS'(lhs_ff);
            unit_b         = OPB_BITS'(lhs_ff);
         end
         swza_pkg::ST_ZZ: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(z_threshold_ff);
            unit_b         = OPB_BITS'(z_threshold_ff);
         end
         swza_pkg::ST_ZD: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(dd_ff);
            unit_b         = OPB_BITS'(zz_ff);
         end
         swza_pkg::ST_MD: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(min_deviation_ff);
            unit_b         = OPB_BITS'(min_deviation_ff);
         end
         swza_pkg::ST_N2: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(count_ff);
            unit_b         = OPB_BITS'(count_ff);
         end
         swza_pkg::ST_FL: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_a         = PROD_BITS'(md2_ff);
            unit_b         = OPB_BITS'(n2_ff);
         end
         swza_pkg::ST_DIV: begin
            unit_ctl.start = ~unit_sts.busy;
            unit_ctl.div   = 1'b1;
            unit_a         = PROD_BITS'(sum_ff);
            unit_b         = OPB_BITS'(count_ff);
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      ptr_in      = ptr_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      sq_in       = sq_ff;
      x_in        = x_ff;
      drop_v_in   = drop_v_ff;
      pre_drop_in = pre_drop_ff;
      eval_in     = eval_ff;
      dd_in       = dd_ff;
      pos_in      = pos_ff;
      lhs_in      = lhs_ff;
      big_in      = big_ff;
      zz_in       = zz_ff;
      above_in    = above_ff;
      md2_in      = md2_ff;
      n2_in       = n2_ff;
      over_in     = over_ff;
      mean_in     = mean_ff;
      case (state_ff)
         swza_pkg::ST_IDLE: begin
            if (req_accept) begin
               x_in        = req_ch.rtt_sample;
               eval_in     = 1'b0;
               pre_drop_in = 1'b1;
            end
         end
         swza_pkg::ST_DROP_SQ: begin
            if (unit_ctl.start) begin
               drop_v_in = ram_rd_data;
            end
            if (unit_sts.done) begin
               sum_in   = (sum_ff > SUM_BITS'(drop_v_ff)) ? sum_ff - SUM_BITS'(drop_v_ff) : '0;
               sq_in    = (sq_ff > v_sq) ? sq_ff - v_sq : '0;
               ptr_in   = ptr_next;
               count_in = count_ff - 1'b1;
            end
         end
         swza_pkg::ST_APPEND: begin
            if (unit_sts.done) begin
               sum_in   = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
               sq_in    = sq_add[SQ_BITS] ? '1 : sq_add[SQ_BITS-1:0];
               count_in = count_ff + 1'b1;
               eval_in  = eval_now;
            end
         end
         swza_pkg::ST_NQ: if (unit_sts.done) dd_in = unit_result[D_BITS-1:0];
         swza_pkg::ST_SS: if (unit_sts.done) dd_in = (dd_ff > ss) ? dd_ff - ss : '0;
         swza_pkg::ST_NX: begin
            if (unit_sts.done) begin
               pos_in = nx > sum_ext;
               lhs_in = {nx - sum_ext, {swza_pkg::Z_FRAC_BITS{1'b0}}};
            end
         end
         swza_pkg::ST_LL: begin
            if (!pos_ff) begin
               above_in = 1'b0;
            end else if (unit_sts.done) begin
               big_in = unit_result[BIG_BITS-1:0];
            end
         end
         swza_pkg::ST_ZZ: if (unit_sts.done) zz_in = unit_result[ZZ_BITS-1:0];
         swza_pkg::ST_ZD: if (unit_sts.done) above_in = PROD_BITS'(big_ff) > unit_result;
         swza_pkg::ST_MD: if (unit_sts.done) md2_in = unit_result[MD2_BITS-1:0];
         swza_pkg::ST_N2: if (unit_sts.done) n2_in = unit_result[N2_BITS-1:0];
         swza_pkg::ST_FL: if (unit_sts.done) over_in = PROD_BITS'(dd_ff) > unit_result;
         swza_pkg::ST_DIV: begin
            if (unit_sts.done) begin
               mean_in     = unit_result[SAMPLE_BITS-1:0];
               pre_drop_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Result register
   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ch.ready);
   assign rsp_eval_in  = rsp_load ? eval_ff : rsp_eval_ff;
   assign rsp_anom_in  = rsp_load ? (eval_ff & above_ff & over_ff) : rsp_anom_ff;
   assign rsp_mean_in  = rsp_load ? (eval_ff ? mean_ff : '0) : rsp_mean_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swza_pkg::ST_IDLE;
         ptr_ff       <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      drop_v_ff   <= drop_v_in;
      pre_drop_ff <= pre_drop_in;
      eval_ff     <= eval_in;
      dd_ff       <= dd_in;
      pos_ff      <= pos_in;
      lhs_ff      <= lhs_in;
      big_ff      <= big_in;
      zz_ff       <= zz_in;
      above_ff    <= above_in;
      md2_ff      <= md2_in;
      n2_ff       <= n2_in;
      over_ff     <= over_in;
      mean_ff     <= mean_in;
      rsp_eval_ff <= rsp_eval_in;
      rsp_anom_ff <= rsp_anom_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.evaluated   = rsp_eval_ff;
   assign rsp_ch.anomaly     = rsp_anom_ff;
   assign rsp_ch.window_mean = rsp_mean_ff;

   swza_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (x_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   swza_unit #(
      .PROD_BITS (PROD_BITS),
      .OPB_BITS  (OPB_BITS),
      .DIV_BITS  (CNT_BITS),
      .QUO_BITS  (SAMPLE_BITS)
   ) u_unit (
      .clock  (clock),
      .reset  (reset),
      .ctl    (unit_ctl),
      .opa    (unit_a),
      .opb    (unit_b),
      .sts    (unit_sts),
      .result (unit_result)
   );

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(WINDOW_DEPTH))
      else $error("window count above store depth");

   a_anomaly_evaluated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_anom_ff |-> rsp_eval_ff)
      else $error("anomaly flagged on an item that was not evaluated");

   a_mean_evaluated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_eval_ff |-> rsp_mean_ff == '0)
      else $error("nonzero mean on an item that was not evaluated");

   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff != swza_pkg::ST_IDLE)
      else $error("sequencer stayed idle after taking an item");

   a_unit_free: assert property (@(posedge clock) disable iff (reset)
      unit_ctl.start |-> !unit_sts.busy)
      else $error("shared unit started while busy");

endmodule

// ===== hdl/swza_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swza_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/swza_unit.sv =====
// Shared digit-serial multiplier and bit-serial divider of the detector.
`timescale 1ns / 1ps

module swza_unit #(
   parameter int unsigned PROD_BITS = 77,
   parameter int unsigned OPB_BITS  = 35,
   parameter int unsigned DIV_BITS  = 7,
   parameter int unsigned QUO_BITS  = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swza_pkg::swza_ctl_type ctl,
   input  logic [PROD_BITS-1:0]   opa,
   input  logic [OPB_BITS-1:0]    opb,
   output swza_pkg::swza_sts_type sts,
   output logic [PROD_BITS-1:0]   result
);

   localparam int unsigned DIGIT     = swza_pkg::MUL_DIGIT_BITS;
   localparam int unsigned STEP_BITS = $clog2(QUO_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 div_ff, div_in;
   logic [PROD_BITS-1:0] a_ff, a_in;
   logic [OPB_BITS-1:0]  b_ff, b_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;
   logic [DIV_BITS-1:0]  rem_ff, rem_in;
   logic [STEP_BITS-1:0] step_ff, step_in;

   logic                 finished;
   logic [PROD_BITS-1:0] partial;
   logic [DIV_BITS:0]    trial;
   logic [DIV_BITS:0]    divisor;
   logic                 trial_ge;

   assign finished = div_ff ? (step_ff == '0) : (b_ff == '0);
   assign partial  = PROD_BITS'(a_ff * PROD_BITS'(b_ff[DIGIT-1:0]));
   assign trial    = {rem_ff, a_ff[QUO_BITS-1]};
   assign divisor  = {1'b0, b_ff[DIV_BITS-1:0]};
   assign trial_ge = (trial >= divisor);

   always_comb begin
      busy_in = busy_ff;
      div_in  = div_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         div_in  = ctl.div;
         a_in    = opa;
         b_in    = opb;
         acc_in  = '0;
         rem_in  = DIV_BITS'(opa >> QUO_BITS);
         step_in = STEP_BITS'(QUO_BITS);
      end else if (busy_ff && finished) begin
         busy_in = 1'b0;
      end else if (busy_ff && div_ff) begin
         rem_in  = trial_ge ? DIV_BITS'(trial - divisor) : trial[DIV_BITS-1:0];
         acc_in  = {acc_ff[PROD_BITS-2:0], trial_ge};
         a_in    = a_ff << 1;
         step_in = step_ff - 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + partial;
         a_in   = a_ff << DIGIT;
         b_in   = b_ff >> DIGIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = busy_ff & finished;
   assign result   = acc_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the sliding-window z-score anomaly detector.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned SAMPLE_W     = swza_pkg::SAMPLE_BITS_DEFAULT;
   localparam int unsigned DEPTH        = swza_pkg::WINDOW_DEPTH_DEFAULT;
   localparam int unsigned PTR_W        = $clog2(DEPTH);
   localparam logic [63:0] SUM_LIMIT    = (64'd1 << 30) - 64'd1;
   localparam logic [63:0] SQSUM_LIMIT  = (64'd1 << 54) - 64'd1;
   localparam int unsigned RANDOM_ITEMS = 1650;
   localparam int unsigned CYCLE_LIMIT  = 1_500_000;
   localparam int unsigned DRAIN_CYCLES = 150;

   typedef struct packed {
      logic                evaluated;
      logic                anomaly;
      logic [SAMPLE_W-1:0] window_mean;
   } verdict_type;

   logic                                clock;
   logic                                reset;
   logic                                csr_write_enable;
   logic [swza_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [swza_pkg::CSR_DATA_BITS-1:0]  csr_write_data;

   swza_req_if #(.SAMPLE_BITS(SAMPLE_W)) req_ch ();
   swza_rsp_if #(.SAMPLE_BITS(SAMPLE_W)) rsp_ch ();

   sliding_window_zscore_anomaly_top #(
      .WINDOW_DEPTH(DEPTH),
      .SAMPLE_BITS (SAMPLE_W)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   logic [SAMPLE_W-1:0] pending_samples[$];
   verdict_type         expected_verdicts[$];
   int unsigned         error_count = 0;
   int unsigned         cycle_count = 0;
   int unsigned         burst_left  = 0;
   int unsigned         gap_left    = 0;
   int unsigned         calm_left   = 0;
   int unsigned         stall_left  = 0;

   logic [SAMPLE_W-1:0]                 win_store[DEPTH];
   logic [PTR_W-1:0]                    win_head;
   int unsigned                         win_count;
   logic [63:0]                         win_sum;
   logic [63:0]                         win_sqsum;
   logic [swza_pkg::COUNT_CFG_BITS-1:0] cfg_min_samples;
   logic [swza_pkg::COUNT_CFG_BITS-1:0] cfg_window_len;
   logic [swza_pkg::Z_BITS-1:0]         cfg_z_threshold;
   logic [swza_pkg::DEV_BITS-1:0]       cfg_min_deviation;

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
      logic [63:0] acc;
      acc = (a > lim) ? lim : a;
      return (b > lim - acc) ? lim : acc + b;
   endfunction

   function automatic void drop_oldest_sample();
      logic [63:0] v;
      v = win_store[win_head];
      win_sum   = (win_sum > v) ? win_sum - v : 64'd0;
      win_sqsum = (win_sqsum > v * v) ? win_sqsum - v * v : 64'd0;
      win_head  = win_head + 1'b1;
      win_count--;
   endfunction

   function automatic verdict_type zscore_predict(logic [SAMPLE_W-1:0] sample);
      verdict_type  v;
      logic [63:0]  x, n, nq, ss, dev_sq, nx, md, floor_sq;
      logic [127:0] lhs, lhs_sq, zsq, rhs_sq;
      logic         above;
      v = '0;
      if (sample == '0) return v;
      x = sample;
      if (win_count >= DEPTH) drop_oldest_sample();
      win_store[win_head + PTR_W'(win_count)] = sample;
      win_count++;
      win_sum   = sat_add(win_sum, x, SUM_LIMIT);
      win_sqsum = sat_add(win_sqsum, x * x, SQSUM_LIMIT);
      n = win_count;
      if (n <= cfg_min_samples) return v;
      nq     = n * win_sqsum;
      ss     = win_sum * win_sum;
      dev_sq = (nq > ss) ? nq - ss : 64'd0;
      nx     = n * x;
      above  = 1'b0;
      if (nx > win_sum) begin
         lhs    = nx - win_sum;
         lhs    = lhs << 4;
         lhs_sq = lhs * lhs;
         zsq    = cfg_z_threshold;
         zsq    = zsq * zsq;
         rhs_sq = zsq * dev_sq;
         above  = lhs_sq > rhs_sq;
      end
      md       = cfg_min_deviation;
      floor_sq = md * md * n * n;
      v.evaluated   = 1'b1;
      v.anomaly     = above && (dev_sq > floor_sq);
      v.window_mean = SAMPLE_W'(win_sum / n);
      if (n > cfg_window_len) drop_oldest_sample();
      return v;
   endfunction

   function automatic logic [SAMPLE_W-1:0] draw_sample(longint base, longint spread);
      int unsigned pick;
      longint      v;
      pick = $urandom_range(0, 99);
      if (pick < 4) v = 0;
      else if (pick < 14) v = $urandom() & 32'hFF_FFFF;
      else if (pick < 22) v = base + spread * $urandom_range(3, 40) + $urandom_range(0, 4096);
      else if (pick < 25) v = $urandom_range(1, 64);
      else v = base - spread + $urandom_range(0, 32'(2 * spread));
      if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
      if (pick >= 4 && v < 1) v = 1;
      return SAMPLE_W'(v);
   endfunction

   function automatic int unsigned pick_setting(int unsigned lo, int unsigned hi,
                                                int unsigned full_max,
                                                int unsigned usual_lo, int unsigned usual_hi);
      case ($urandom_range(0, 5))
         0: return lo;
         1: return hi;
         2: return $urandom_range(0, full_max);
         default: return $urandom_range(usual_lo, usual_hi);
      endcase
   endfunction

   task automatic write_register(swza_pkg::swza_csr_type idx,
                                 logic [swza_pkg::CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         swza_pkg::CSR_MIN_SAMPLES:
            cfg_min_samples = data[swza_pkg::COUNT_CFG_BITS-1:0];
         swza_pkg::CSR_WINDOW_LEN:
            cfg_window_len = data[swza_pkg::COUNT_CFG_BITS-1:0];
         swza_pkg::CSR_Z_THRESHOLD:
            cfg_z_threshold = data[swza_pkg::Z_BITS-1:0];
         swza_pkg::CSR_MIN_DEVIATION:
            cfg_min_deviation = data[swza_pkg::DEV_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(int unsigned ms, int unsigned wl, int unsigned z,
                                 int unsigned md);
      write_register(swza_pkg::CSR_MIN_SAMPLES, 16'(($urandom_range(0, 1023) << 6) | ms));
      write_register(swza_pkg::CSR_WINDOW_LEN, 16'(($urandom_range(0, 1023) << 6) | wl));
      write_register(swza_pkg::CSR_Z_THRESHOLD, 16'(($urandom_range(0, 255) << 8) | z));
      write_register(swza_pkg::CSR_MIN_DEVIATION, 16'(md));
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_ch.valid || expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin : drive_samples
      logic                next_valid;
      logic [SAMPLE_W-1:0] next_sample;
      next_valid  = req_ch.valid;
      next_sample = req_ch.rtt_sample;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_verdicts.insert(expected_verdicts.size(),
                                     zscore_predict(req_ch.rtt_sample));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_samples.size() > 0) begin
               next_valid  = 1'b1;
               next_sample = pending_samples.pop_front();
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 30);
                  case ($urandom_range(0, 7))
                     0, 1, 2: gap_left = 0;
                     7:       gap_left = $urandom_range(20, 130);
                     default: gap_left = $urandom_range(1, 8);
                  endcase
               end
            end
         end
      end
      req_ch.valid      <= next_valid;
      req_ch.rtt_sample <= next_sample;
   end

   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      logic        next_ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_verdicts.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item: expected none, actual eval %b anom %b mean %0d",
                     $time, rsp_ch.evaluated, rsp_ch.anomaly, rsp_ch.window_mean);
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_ch.evaluated !== want.evaluated) begin
               error_count++;
               $display("%0t: evaluated: expected %b, actual %b",
                        $time, want.evaluated, rsp_ch.evaluated);
            end
            if (rsp_ch.anomaly !== want.anomaly) begin
               error_count++;
               $display("%0t: anomaly: expected %b, actual %b",
                        $time, want.anomaly, rsp_ch.anomaly);
            end
            if (rsp_ch.window_mean !== want.window_mean) begin
               error_count++;
               $display("%0t: window_mean: expected %0d, actual %0d",
                        $time, want.window_mean, rsp_ch.window_mean);
            end
         end
      end
      if (calm_left > 0) begin
         calm_left--;
         next_ready = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         next_ready = 1'b0;
      end else begin
         next_ready = 1'b1;
         case ($urandom_range(0, 15))
            0:       calm_left  = $urandom_range(50, 600);
            1, 2, 3: stall_left = $urandom_range(1, 6);
            4:       stall_left = $urandom_range(7, 40);
            default: ;
         endcase
      end
      rsp_ch.ready <= next_ready;
   end

   initial begin : run_phases
      int unsigned         issued;
      int unsigned         batch;
      int unsigned         phase;
      longint              base;
      longint              spread;
      logic [SAMPLE_W-1:0] sample;

      clock             = 1'b0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.rtt_sample = '0;
      rsp_ch.ready      = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      win_head          = '0;
      win_count         = 0;
      win_sum           = '0;
      win_sqsum         = '0;
      cfg_min_samples   = swza_pkg::MIN_SAMPLES_RESET;
      cfg_window_len    = swza_pkg::WINDOW_LEN_RESET;
      cfg_z_threshold   = swza_pkg::Z_THRESHOLD_RESET;
      cfg_min_deviation = swza_pkg::MIN_DEVIATION_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // register defaults: extremes, then a steady run with a spike
      pending_samples = '{'0, 24'hFF_FFFF, 24'd1, 24'h80_0000, 24'h7F_FFFF,
                          24'd1000, 24'd1003, 24'd998, 24'd1001, 24'd999, 24'd1002, 24'd1000,
                          '0, 24'h55_5555, 24'hAA_AAAA};
      wait_idle();

      // lowest settings: evaluate at once, no z margin, no floor
      apply_settings(1, 2, 0, 0);
      pending_samples = '{24'd5, 24'd5, 24'hFF_FFFF, 24'd1, '0};
      wait_idle();

      issued = 0;
      phase  = 0;
      while (issued < RANDOM_ITEMS) begin
         if (phase == 0)
            apply_settings(62, 63, 255, 65535);
         else
            apply_settings(pick_setting(1, 62, 63, 1, 16), pick_setting(2, 63, 63, 8, 63),
                           pick_setting(0, 255, 255, 8, 64),
                           pick_setting(0, 65535, 65535, 0, 2048));
         case ($urandom_range(0, 2))
            0:       base = $urandom_range(1, 2000);
            1:       base = $urandom_range(2000, 200000);
            default: base = $urandom_range(200000, 24'hF0_0000);
         endcase
         spread = $urandom_range(0, 32'(base / 4));
         batch  = $urandom_range(60, 180);
         repeat (batch) begin
            if ($urandom_range(0, 39) == 0) begin
               base   = $urandom_range(1, 24'hF0_0000);
               spread = $urandom_range(0, 32'(base / 4));
            end
            sample = draw_sample(base, spread);
            pending_samples.insert(pending_samples.size(), sample);
            if (sample != '0) issued++;
         end
         wait_idle();
         phase++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
